FILE: hw/rtl/grid_maze_path_search_macros.svh
`ifndef GRID_MAZE_PATH_SEARCH_MACROS_SVH
`define GRID_MAZE_PATH_SEARCH_MACROS_SVH

// same-cycle implication on the block clock, held off during reset
`define GMPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, held off during reset
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gmps_pkg.sv
package gmps_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // search directions, tried in this order; DIR_DONE means all tried
    localparam int DIR_W = 3;
    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_DONE  = 3'd4
    } dir_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_START_RD,
        ST_START_CK,
        ST_STEP,
        ST_PROBE,
        ST_POP
    } state_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd5;

    localparam logic [7:0] GRID_SIZE_RESET = 8'd128;

    // field widths
    localparam int COORD_W = 7;
    localparam int LEN_W   = 15;

    // per-cell mark word: bit 1 visited, bit 0 on path
    localparam int MARK_W        = 2;
    localparam int MARK_PATH_BIT = 0;
    localparam int MARK_SEEN_BIT = 1;
    localparam logic [MARK_W-1:0] MARK_CLEAR   = 2'b00;
    localparam logic [MARK_W-1:0] MARK_SEEN    = 2'b10;
    localparam logic [MARK_W-1:0] MARK_ON_PATH = 2'b11;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               wall;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] path_length;
        logic             cell_wall;
        logic             cell_on_path;
    } out_item_t;

endpackage

FILE: hw/rtl/gmps_ram.sv
module gmps_ram
    import gmps_pkg::*;
#(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/grid_maze_path_search.sv
// Grid maze solver: a wall/open cell grid searched depth first.
// Input channel s_valid/s_ready/s_payload carries one beat per item: write a
// cell, solve, read a cell, or no operation. Every item gives exactly one result
// beat on m_valid/m_ready/m_payload with the status of the last solve; a read
// also returns the cell's wall bit and on-path mark. Configuration (grid size,
// start, goal) is written on cfg_valid/cfg_index/cfg_data, always ready.
// A write or no-op result shows in the cycle after the beat; reads pass ST_READ.
// A write may follow a write in every cycle while each result is taken.
// A solve first sweeps the mark memory, one entry a cycle (MAX_SIDE^2 rounded
// up to a power of two in each side, 16384 entries by default), then reads and
// checks the start cell (ST_START_RD, ST_START_CK). A direction off the grid
// uses ST_STEP, a cell lookup ST_STEP and ST_PROBE, a backtrack ST_STEP and
// ST_POP. All lookups share a read port per memory, which sets the search pace.
// After reset the block clears the wall and mark memories in the same sweep
// length with s_ready low; configuration writes are taken meanwhile.
// A held-off result waits in the output register; the next item is taken only
// once that register is free or being emptied in the same cycle.
module grid_maze_path_search
    import gmps_pkg::*;
#(
    parameter int MAX_SIDE = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = AW + 1;
    localparam logic [8:0] SIDE = 9'(MAX_SIDE);

    // configuration registers
    logic [7:0]         grid_rows_reg, grid_cols_reg;
    logic [COORD_W-1:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;

    // sequencer and datapath registers
    state_t           state_reg, state_next;
    logic [AW-1:0]    sweep_reg, sweep_next;
    logic [CW-1:0]    cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [CW-1:0]    nbr_row_reg, nbr_row_next, nbr_col_reg, nbr_col_next;
    dir_t             dir_reg, dir_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic             rd_inside_reg, rd_inside_next;
    logic             found_reg, found_next;
    logic [LEN_W-1:0] path_len_reg, path_len_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_payload_reg, m_payload_next;

    // memory ports
    logic              wall_we, wall_wd, wall_rd;
    logic [AW-1:0]     wall_wa, wall_ra;
    logic              mark_we;
    logic [AW-1:0]     mark_wa, mark_ra;
    logic [MARK_W-1:0] mark_wd, mark_rd;
    logic              stk_we;
    logic [AW-1:0]     stk_wa, stk_ra;
    logic [DIR_W-1:0]  stk_wd, stk_rd;

    // shared decode
    logic          s_accept;
    logic [8:0]    rows_eff, cols_eff;
    logic          in_inside;
    logic [AW-1:0] in_addr, start_addr, cur_addr, nbr_addr, nbr_w_addr;
    logic          start_in, start_fail, start_trivial;
    logic [8:0]    nbr_row_w, nbr_col_w;
    logic          nbr_ok;
    logic          probe_blocked, probe_goal;
    logic          sweep_last;
    logic [DW-1:0] top_idx, below_idx;
    dir_t          came_dir;

    assign s_accept  = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // grid size clamped to the store
    assign rows_eff = (9'(grid_rows_reg) > SIDE) ? SIDE : 9'(grid_rows_reg);
    assign cols_eff = (9'(grid_cols_reg) > SIDE) ? SIDE : 9'(grid_cols_reg);

    // cell addresses
    assign in_inside  = (9'(s_payload.row) < SIDE) && (9'(s_payload.col) < SIDE);
    assign in_addr    = {CW'(s_payload.row), CW'(s_payload.col)};
    assign start_addr = {CW'(start_row_reg), CW'(start_col_reg)};
    assign cur_addr   = {cur_row_reg, cur_col_reg};
    assign nbr_addr   = {nbr_row_reg, nbr_col_reg};
    assign nbr_w_addr = {nbr_row_w[CW-1:0], nbr_col_w[CW-1:0]};

    // start cell checks
    assign start_in      = (9'(start_row_reg) < rows_eff) && (9'(start_col_reg) < cols_eff);
    assign start_fail    = !start_in || wall_rd;
    assign start_trivial = (start_row_reg == goal_row_reg) && (start_col_reg == goal_col_reg);

    // neighbour in the direction being tried, with its bounds check
    always_comb begin
        nbr_row_w = 9'(cur_row_reg);
        nbr_col_w = 9'(cur_col_reg);
        nbr_ok    = 1'b0;
        case (dir_reg)
            DIR_DOWN: begin
                nbr_row_w = 9'(cur_row_reg) + 9'd1;
                nbr_ok    = nbr_row_w < rows_eff;
            end
            DIR_UP: begin
                nbr_row_w = 9'(cur_row_reg) - 9'd1;
                nbr_ok    = cur_row_reg != '0;
            end
            DIR_RIGHT: begin
                nbr_col_w = 9'(cur_col_reg) + 9'd1;
                nbr_ok    = nbr_col_w < cols_eff;
            end
            DIR_LEFT: begin
                nbr_col_w = 9'(cur_col_reg) - 9'd1;
                nbr_ok    = cur_col_reg != '0;
            end
            default: begin
                nbr_ok = 1'b0;
            end
        endcase
    end

    // looked-up neighbour
    assign probe_blocked = wall_rd || mark_rd[MARK_SEEN_BIT];
    assign probe_goal    = (9'(nbr_row_reg) == 9'(goal_row_reg))
                        && (9'(nbr_col_reg) == 9'(goal_col_reg));

    assign sweep_last = &sweep_reg;
    assign top_idx    = depth_reg - DW'(1);
    assign below_idx  = depth_reg - DW'(2);
    assign came_dir   = dir_t'(stk_rd - DIR_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_payload.op)
                        OP_READ:  state_next = ST_READ;
                        OP_SOLVE: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: state_next = ST_IDLE;
            ST_CLEAR: begin
                if (sweep_last) state_next = ST_START_RD;
            end
            ST_START_RD: state_next = ST_START_CK;
            ST_START_CK: begin
                state_next = (start_fail || start_trivial) ? ST_IDLE : ST_STEP;
            end
            ST_STEP: begin
                if (dir_reg == DIR_DONE) begin
                    state_next = (depth_reg == DW'(1)) ? ST_IDLE : ST_POP;
                end else if (nbr_ok) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (probe_blocked) state_next = ST_STEP;
                else if (probe_goal) state_next = ST_IDLE;
                else state_next = ST_STEP;
            end
            ST_POP: state_next = ST_STEP;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, memory controls and result
    always_comb begin
        sweep_next     = sweep_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        nbr_row_next   = nbr_row_reg;
        nbr_col_next   = nbr_col_reg;
        dir_next       = dir_reg;
        depth_next     = depth_reg;
        rd_inside_next = rd_inside_reg;
        found_next     = found_reg;
        path_len_next  = path_len_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        wall_we = 1'b0;
        wall_wa = sweep_reg;
        wall_wd = 1'b0;
        wall_ra = in_addr;
        mark_we = 1'b0;
        mark_wa = sweep_reg;
        mark_wd = MARK_CLEAR;
        mark_ra = in_addr;
        stk_we  = 1'b0;
        stk_wa  = top_idx[AW-1:0];
        stk_wd  = dir_reg;
        stk_ra  = below_idx[AW-1:0];

        case (state_reg)
            // power-up sweep of walls and marks
            ST_INIT: begin
                wall_we    = 1'b1;
                mark_we    = 1'b1;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_payload.op)
                        OP_WRITE: begin
                            wall_we        = in_inside;
                            wall_wa        = in_addr;
                            wall_wd        = s_payload.wall;
                            m_valid_next   = 1'b1;
                            m_payload_next = '{found: found_reg, path_length: path_len_reg,
                                               cell_wall: 1'b0, cell_on_path: 1'b0};
                        end
                        OP_READ: begin
                            rd_inside_next = in_inside;
                        end
                        OP_SOLVE: begin
                            sweep_next = '0;
                        end
                        default: begin
                            m_valid_next   = 1'b1;
                            m_payload_next = '{found: found_reg, path_length: path_len_reg,
                                               cell_wall: 1'b0, cell_on_path: 1'b0};
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next   = 1'b1;
                m_payload_next = '{found: found_reg, path_length: path_len_reg,
                                   cell_wall: rd_inside_reg && wall_rd,
                                   cell_on_path: rd_inside_reg && mark_rd[MARK_PATH_BIT]};
            end
            // clear marks of the previous solve
            ST_CLEAR: begin
                mark_we    = 1'b1;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_START_RD: begin
                wall_ra = start_addr;
            end
            ST_START_CK: begin
                if (start_fail || start_trivial) begin
                    found_next     = !start_fail;
                    path_len_next  = '0;
                    m_valid_next   = 1'b1;
                    m_payload_next = '{found: !start_fail, path_length: '0,
                                       cell_wall: 1'b0, cell_on_path: 1'b0};
                end else begin
                    mark_we      = 1'b1;
                    mark_wa      = start_addr;
                    mark_wd      = MARK_SEEN;
                    cur_row_next = CW'(start_row_reg);
                    cur_col_next = CW'(start_col_reg);
                    dir_next     = DIR_DOWN;
                    depth_next   = DW'(1);
                end
            end
            ST_STEP: begin
                if (dir_reg == DIR_DONE) begin
                    // backtrack: unmark the cell but keep it visited
                    mark_we    = depth_reg != DW'(1);
                    mark_wa    = cur_addr;
                    mark_wd    = MARK_SEEN;
                    depth_next = top_idx;
                    if (depth_reg == DW'(1)) begin
                        found_next     = 1'b0;
                        path_len_next  = '0;
                        m_valid_next   = 1'b1;
                        m_payload_next = '{found: 1'b0, path_length: '0,
                                           cell_wall: 1'b0, cell_on_path: 1'b0};
                    end
                end else begin
                    dir_next     = dir_t'(dir_reg + DIR_W'(1));
                    nbr_row_next = nbr_row_w[CW-1:0];
                    nbr_col_next = nbr_col_w[CW-1:0];
                    wall_ra      = nbr_w_addr;
                    mark_ra      = nbr_w_addr;
                end
            end
            ST_PROBE: begin
                if (!probe_blocked) begin
                    if (probe_goal) begin
                        found_next     = 1'b1;
                        path_len_next  = LEN_W'(top_idx);
                        m_valid_next   = 1'b1;
                        m_payload_next = '{found: 1'b1, path_length: LEN_W'(top_idx),
                                           cell_wall: 1'b0, cell_on_path: 1'b0};
                    end else begin
                        // push: save the tried count, move into the neighbour
                        mark_we      = 1'b1;
                        mark_wa      = nbr_addr;
                        mark_wd      = MARK_ON_PATH;
                        stk_we       = 1'b1;
                        depth_next   = depth_reg + DW'(1);
                        cur_row_next = nbr_row_reg;
                        cur_col_next = nbr_col_reg;
                        dir_next     = DIR_DOWN;
                    end
                end
            end
            // step back to the parent, opposite to the way we came in
            ST_POP: begin
                dir_next = dir_t'(stk_rd);
                case (came_dir)
                    DIR_DOWN:  cur_row_next = cur_row_reg - CW'(1);
                    DIR_UP:    cur_row_next = cur_row_reg + CW'(1);
                    DIR_RIGHT: cur_col_next = cur_col_reg - CW'(1);
                    DIR_LEFT:  cur_col_next = cur_col_reg + CW'(1);
                    default:   cur_row_next = cur_row_reg;
                endcase
            end
            default: begin
                sweep_next = sweep_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            depth_reg     <= '0;
            dir_reg       <= DIR_DOWN;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            found_reg     <= 1'b0;
            path_len_reg  <= '0;
            m_valid_reg   <= 1'b0;
            grid_rows_reg <= GRID_SIZE_RESET;
            grid_cols_reg <= GRID_SIZE_RESET;
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= '0;
            goal_col_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            depth_reg    <= depth_next;
            dir_reg      <= dir_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            found_reg    <= found_next;
            path_len_reg <= path_len_next;
            m_valid_reg  <= m_valid_next;
            // configuration beat
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                    CFG_START_ROW: start_row_reg <= cfg_data[COORD_W-1:0];
                    CFG_START_COL: start_col_reg <= cfg_data[COORD_W-1:0];
                    CFG_GOAL_ROW:  goal_row_reg  <= cfg_data[COORD_W-1:0];
                    CFG_GOAL_COL:  goal_col_reg  <= cfg_data[COORD_W-1:0];
                    default:       grid_rows_reg <= grid_rows_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        nbr_row_reg   <= nbr_row_next;
        nbr_col_reg   <= nbr_col_next;
        rd_inside_reg <= rd_inside_next;
        m_payload_reg <= m_payload_next;
    end

    // wall bits
    gmps_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_wall_ram (
        .aclk    (aclk),
        .wr_en   (wall_we),
        .wr_addr (wall_wa),
        .wr_data (wall_wd),
        .rd_addr (wall_ra),
        .rd_data (wall_rd)
    );

    // visited and on-path marks
    gmps_ram #(
        .WIDTH (MARK_W),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (mark_we),
        .wr_addr (mark_wa),
        .wr_data (mark_wd),
        .rd_addr (mark_ra),
        .rd_data (mark_rd)
    );

    // tried-direction count of each cell below the top of the search
    gmps_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_wa),
        .wr_data (stk_wd),
        .rd_addr (stk_ra),
        .rd_data (stk_rd)
    );

endmodule

FILE: hw/rtl/gmps_checker.sv
`include "grid_maze_path_search_macros.svh"

module gmps_checker
    import gmps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_item_t              s_payload,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_payload,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // an item is only taken when the result register can take its beat
    `GMPS_ASSERT_NOW(a_ready_needs_slot, s_ready, !m_valid || m_ready, "input taken while result blocked")

    // a cell write answers in the very next cycle
    `GMPS_ASSERT_NEXT(a_write_answers, s_valid && s_ready && s_payload.op == OP_WRITE, m_valid, "write beat gave no result")

    // a failed solve never reports a path
    `GMPS_ASSERT_NOW(a_len_needs_found, m_valid && !m_payload.found, m_payload.path_length == '0, "path length without found")

    // a stalled result holds
    `GMPS_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_payload), "stalled result changed")

endmodule

bind grid_maze_path_search gmps_checker u_gmps_checker (.*);
